[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the dependence element ALU modules.
// They expect signals named clk and arst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/dea_pkg.sv]
// ---------------------------------------------------------------------------
// Dependence element ALU package
// Widths, codes and stage payload types shared by the pipeline stages.
// ---------------------------------------------------------------------------
package dea_pkg;

	localparam int DIST_W = 16;
	// Negated distance needs one more bit, a sum of two such values one more.
	localparam int NEG_W  = DIST_W + 1;
	localparam int SUM_W  = DIST_W + 2;
	// Wide enough for the full product of two distances.
	localparam int WIDE_W = 2 * DIST_W;

	typedef enum logic [1:0] {
		KIND_EXACT    = 2'd0,
		KIND_AT_LEAST = 2'd1,
		KIND_AT_MOST  = 2'd2,
		KIND_UNKNOWN  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		VERD_FALSE   = 2'd0,
		VERD_TRUE    = 2'd1,
		VERD_UNKNOWN = 2'd2
	} verdict_t;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_NEG = 4'd3,
		CMD_GT  = 4'd4,
		CMD_LT  = 4'd5,
		CMD_GE  = 4'd6,
		CMD_LE  = 4'd7,
		CMD_EQ  = 4'd8,
		CMD_NE  = 4'd9
	} cmd_t;

	// Normalised operands; c is the second addend (b, or -b for a subtract).
	typedef struct packed {
		logic [3:0]               cmd;
		kind_t                    a_kind;
		logic signed [DIST_W-1:0] a_dist;
		kind_t                    b_kind;
		logic signed [DIST_W-1:0] b_dist;
		kind_t                    c_kind;
		logic signed [NEG_W-1:0]  c_dist;
	} opnd_t;

	// Unsaturated result element and verdict.
	typedef struct packed {
		kind_t                    kind;
		logic signed [WIDE_W-1:0] wdist;
		verdict_t                 verdict;
	} raw_t;

	// Negation swaps a lower bound for an upper bound and back.
	function automatic kind_t flip_kind(input kind_t k);
		kind_t r;
		unique case (k)
			KIND_AT_LEAST: r = KIND_AT_MOST;
			KIND_AT_MOST:  r = KIND_AT_LEAST;
			default:       r = k;
		endcase
		return r;
	endfunction

endpackage

[rtl/dea_operand.sv]
// ---------------------------------------------------------------------------
// Operand stage
// Registers the incoming transaction, clears the distance of unknown
// operands and forms the second addend for add and subtract.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dea_operand
	import dea_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               cmd,
	input  logic [1:0]               a_kind,
	input  logic signed [DIST_W-1:0] a_dist,
	input  logic [1:0]               b_kind,
	input  logic signed [DIST_W-1:0] b_dist,
	output logic                     op_valid,
	input  logic                     op_ready,
	output opnd_t                    op
);

	logic  valid_s1;
	opnd_t opnd_s1;
	opnd_t opnd_d;

	always_comb begin
		opnd_d.cmd    = cmd;
		opnd_d.a_kind = kind_t'(a_kind);
		opnd_d.b_kind = kind_t'(b_kind);
		opnd_d.a_dist = (opnd_d.a_kind == KIND_UNKNOWN) ? '0 : a_dist;
		opnd_d.b_dist = (opnd_d.b_kind == KIND_UNKNOWN) ? '0 : b_dist;
		if (cmd == CMD_SUB) begin
			opnd_d.c_kind = flip_kind(opnd_d.b_kind);
			opnd_d.c_dist = -(NEG_W'(opnd_d.b_dist));
		end else begin
			opnd_d.c_kind = opnd_d.b_kind;
			opnd_d.c_dist = NEG_W'(opnd_d.b_dist);
		end
	end

	assign in_ready = !valid_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opnd_s1 <= opnd_d;
		end
	end

	assign op_valid = valid_s1;
	assign op       = opnd_s1;

	// A stalled transaction must neither vanish nor change.
	`ASSERT_RST(a_s1_hold, valid_s1 && !op_ready |=> valid_s1 && $stable(opnd_s1), "stage 1 lost a stalled transaction")

endmodule

[rtl/dea_compute.sv]
// ---------------------------------------------------------------------------
// Compute stage
// Forms the exact sum, product and negation with their result kinds, and
// the three-valued comparison verdicts, then registers the selected result.
// ---------------------------------------------------------------------------
module dea_compute
	import dea_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  op_valid,
	output logic  op_ready,
	input  opnd_t op,
	output logic  raw_valid,
	input  logic  raw_ready,
	output raw_t  raw
);

	// Strict order when the first element is an exact distance.
	function automatic verdict_t gt_exact_first(
		input logic signed [DIST_W-1:0] ed,
		input kind_t                    ok,
		input logic signed [DIST_W-1:0] od
	);
		verdict_t v;
		logic     e_neg;
		logic     e_zero;
		logic     o_neg;
		logic     o_pos;
		e_neg  = ed[DIST_W-1];
		e_zero = (ed == '0);
		o_neg  = od[DIST_W-1];
		o_pos  = !od[DIST_W-1] && (od != '0);
		v      = VERD_UNKNOWN;
		priority if (!e_neg && !e_zero) begin
			priority if (ok == KIND_AT_MOST) v = VERD_TRUE;
			else if (ok == KIND_AT_LEAST && ed < od) v = VERD_FALSE;
			else v = VERD_UNKNOWN;
		end else if (e_zero) begin
			priority if (ok == KIND_AT_MOST && o_neg) v = VERD_TRUE;
			else if (ok == KIND_AT_LEAST && o_pos) v = VERD_FALSE;
			else v = VERD_UNKNOWN;
		end else begin
			priority if (ok == KIND_AT_LEAST) v = VERD_FALSE;
			else if (ok == KIND_AT_MOST && ed > od) v = VERD_TRUE;
			else v = VERD_UNKNOWN;
		end
		return v;
	endfunction

	function automatic verdict_t swap_verdict(input verdict_t v);
		verdict_t r;
		unique case (v)
			VERD_TRUE:  r = VERD_FALSE;
			VERD_FALSE: r = VERD_TRUE;
			default:    r = v;
		endcase
		return r;
	endfunction

	function automatic verdict_t greater(
		input kind_t                    xk,
		input logic signed [DIST_W-1:0] xd,
		input kind_t                    yk,
		input logic signed [DIST_W-1:0] yd
	);
		verdict_t v;
		priority if (xk == KIND_EXACT && yk == KIND_EXACT) begin
			v = (xd > yd) ? VERD_TRUE : VERD_FALSE;
		end else if (xk == KIND_EXACT) begin
			v = gt_exact_first(xd, yk, yd);
		end else if (yk == KIND_EXACT) begin
			v = swap_verdict(gt_exact_first(yd, xk, xd));
		end else if (xk == KIND_AT_LEAST && yk == KIND_AT_MOST && xd > yd) begin
			v = VERD_TRUE;
		end else if (xk == KIND_AT_MOST && yk == KIND_AT_LEAST && xd < yd) begin
			v = VERD_FALSE;
		end else begin
			v = VERD_UNKNOWN;
		end
		return v;
	endfunction

	logic                     valid_s2;
	raw_t                     raw_s2;
	raw_t                     raw_d;
	logic signed [SUM_W-1:0]  sum;
	logic signed [WIDE_W-1:0] prod;
	logic                     sum_pos;
	logic                     sum_neg;
	logic                     add_chk;
	kind_t                    add_base;
	kind_t                    add_kind;
	kind_t                    mul_kind;
	kind_t                    other_kind;
	logic signed [DIST_W-1:0] exact_dist;
	logic                     same;
	verdict_t                 gt_ab;
	verdict_t                 gt_ba;

	always_comb begin
		sum     = SUM_W'(op.a_dist) + SUM_W'(op.c_dist);
		prod    = WIDE_W'(op.a_dist) * WIDE_W'(op.b_dist);
		sum_neg = sum[SUM_W-1];
		sum_pos = !sum[SUM_W-1] && (sum != '0);

		// An exact addend keeps the other kind unless the bound lands on the
		// wrong side of zero.
		add_chk = 1'b0;
		priority if (op.a_kind == KIND_EXACT) begin
			add_base = op.c_kind;
			add_chk  = 1'b1;
		end else if (op.c_kind == KIND_EXACT) begin
			add_base = op.a_kind;
			add_chk  = 1'b1;
		end else if (op.a_kind == KIND_UNKNOWN || op.c_kind == KIND_UNKNOWN) begin
			add_base = KIND_UNKNOWN;
		end else if (op.a_kind == op.c_kind) begin
			add_base = op.a_kind;
		end else begin
			add_base = KIND_UNKNOWN;
		end
		add_kind = (add_chk && ((sum_pos && add_base == KIND_AT_MOST) ||
			(sum_neg && add_base == KIND_AT_LEAST))) ? KIND_UNKNOWN : add_base;

		// With one exact factor, its sign decides whether the bound is kept.
		other_kind = (op.a_kind == KIND_EXACT) ? op.b_kind : op.a_kind;
		exact_dist = (op.a_kind == KIND_EXACT) ? op.a_dist : op.b_dist;
		priority if (op.a_kind == KIND_UNKNOWN) begin
			mul_kind = KIND_UNKNOWN;
		end else if (op.a_kind == KIND_EXACT && op.b_kind == KIND_EXACT) begin
			mul_kind = KIND_EXACT;
		end else if (op.a_kind == KIND_EXACT || op.b_kind == KIND_EXACT) begin
			priority if (other_kind == KIND_UNKNOWN) begin
				mul_kind = (exact_dist == '0) ? KIND_EXACT : KIND_UNKNOWN;
			end else if (exact_dist == '0) begin
				mul_kind = KIND_EXACT;
			end else if (!exact_dist[DIST_W-1]) begin
				mul_kind = other_kind;
			end else begin
				mul_kind = flip_kind(other_kind);
			end
		end else if (op.b_kind == KIND_UNKNOWN) begin
			mul_kind = KIND_UNKNOWN;
		end else if (op.a_kind == op.b_kind) begin
			mul_kind = KIND_AT_LEAST;
		end else begin
			mul_kind = KIND_AT_MOST;
		end

		same  = (op.a_kind == KIND_UNKNOWN && op.b_kind == KIND_UNKNOWN) ||
			(op.a_kind == op.b_kind && op.a_dist == op.b_dist);
		gt_ab = greater(op.a_kind, op.a_dist, op.b_kind, op.b_dist);
		gt_ba = greater(op.b_kind, op.b_dist, op.a_kind, op.a_dist);

		raw_d.kind    = KIND_EXACT;
		raw_d.wdist   = '0;
		raw_d.verdict = VERD_FALSE;
		unique case (op.cmd)
			CMD_ADD, CMD_SUB: begin
				raw_d.kind  = add_kind;
				raw_d.wdist = WIDE_W'(sum);
			end
			CMD_MUL: begin
				raw_d.kind  = mul_kind;
				raw_d.wdist = prod;
			end
			CMD_NEG: begin
				raw_d.kind  = flip_kind(op.a_kind);
				raw_d.wdist = -(WIDE_W'(op.a_dist));
			end
			CMD_GT: raw_d.verdict = gt_ab;
			CMD_LT: raw_d.verdict = gt_ba;
			CMD_GE: raw_d.verdict = same ? VERD_TRUE : gt_ab;
			CMD_LE: raw_d.verdict = same ? VERD_TRUE : gt_ba;
			CMD_EQ: raw_d.verdict = same ? VERD_TRUE : VERD_FALSE;
			CMD_NE: raw_d.verdict = same ? VERD_FALSE : VERD_TRUE;
			default: raw_d.verdict = VERD_FALSE;
		endcase
	end

	assign op_ready = !valid_s2 || raw_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (op_ready) begin
			valid_s2 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			raw_s2 <= raw_d;
		end
	end

	assign raw_valid = valid_s2;
	assign raw       = raw_s2;

endmodule

[rtl/dea_resolve.sv]
// ---------------------------------------------------------------------------
// Resolve stage
// Clears the distance of an unknown result, saturates the distance to the
// element range and holds the result for the output channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dea_resolve
	import dea_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     raw_valid,
	output logic                     raw_ready,
	input  raw_t                     raw,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               res_kind,
	output logic signed [DIST_W-1:0] res_dist,
	output logic [1:0]               verdict,
	output logic                     overflow
);

	localparam logic signed [WIDE_W-1:0] DIST_MAX = WIDE_W'({1'b0, {(DIST_W-1){1'b1}}});
	localparam logic signed [WIDE_W-1:0] DIST_MIN = ~DIST_MAX;

	logic                     valid_s3;
	kind_t                    kind_s3;
	logic signed [DIST_W-1:0] dist_s3;
	verdict_t                 verdict_s3;
	logic                     ovf_s3;
	logic signed [DIST_W-1:0] dist_d;
	logic                     ovf_d;

	// Comparison transactions arrive with a zero exact element, so they
	// never saturate.
	always_comb begin
		ovf_d  = 1'b0;
		dist_d = raw.wdist[DIST_W-1:0];
		priority if (raw.kind == KIND_UNKNOWN) begin
			dist_d = '0;
		end else if (raw.wdist > DIST_MAX) begin
			dist_d = DIST_MAX[DIST_W-1:0];
			ovf_d  = 1'b1;
		end else if (raw.wdist < DIST_MIN) begin
			dist_d = DIST_MIN[DIST_W-1:0];
			ovf_d  = 1'b1;
		end else begin
			dist_d = raw.wdist[DIST_W-1:0];
		end
	end

	assign raw_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (raw_ready) begin
			valid_s3 <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_valid && raw_ready) begin
			kind_s3    <= raw.kind;
			dist_s3    <= dist_d;
			verdict_s3 <= raw.verdict;
			ovf_s3     <= ovf_d;
		end
	end

	assign out_valid = valid_s3;
	assign res_kind  = kind_s3;
	assign res_dist  = dist_s3;
	assign verdict   = verdict_s3;
	assign overflow  = ovf_s3;

	`ASSERT_RST(a_ovf_known, valid_s3 && ovf_s3 |-> kind_s3 != KIND_UNKNOWN, "overflow on an unknown result")
	`ASSERT_RST(a_unknown_zero, valid_s3 && kind_s3 == KIND_UNKNOWN |-> dist_s3 == '0, "unknown result with a distance")
	`ASSERT_RST(a_verdict_only, valid_s3 && verdict_s3 != VERD_FALSE |-> kind_s3 == KIND_EXACT && dist_s3 == '0 && !ovf_s3, "comparison result carries an element")

endmodule

[rtl/dependence_element_alu.sv]
// ---------------------------------------------------------------------------
// Dependence element ALU
// Throughput: one transaction per cycle through three register stages while the output is not stalled.
// A stall at the output backs up stage by stage; nothing is lost.
// Reset clears the stage valid bits only; no clearing pass is needed.
// ---------------------------------------------------------------------------
module dependence_element_alu
	import dea_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               cmd,
	input  logic [1:0]               a_kind,
	input  logic signed [DIST_W-1:0] a_dist,
	input  logic [1:0]               b_kind,
	input  logic signed [DIST_W-1:0] b_dist,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               res_kind,
	output logic signed [DIST_W-1:0] res_dist,
	output logic [1:0]               verdict,
	output logic                     overflow
);

	logic  op_valid;
	logic  op_ready;
	opnd_t op;
	logic  raw_valid;
	logic  raw_ready;
	raw_t  raw;

	dea_operand u_operand (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.a_kind   (a_kind),
		.a_dist   (a_dist),
		.b_kind   (b_kind),
		.b_dist   (b_dist),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	dea_compute u_compute (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw       (raw)
	);

	dea_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw       (raw),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_kind  (res_kind),
		.res_dist  (res_dist),
		.verdict   (verdict),
		.overflow  (overflow)
	);

endmodule
